// ----- sv/fvcr_pkg.sv -----
// ---------------------------------------------------------------------------
// fvcr_pkg: shared types and constants of the framed valve command receiver
// Frame status codes, parser states, register indexes and the result record.
// ---------------------------------------------------------------------------
package fvcr_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned VALVE_W  = 7;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [BYTE_W-1:0] START_BYTE_RESET  = 8'h23;
   localparam logic [BYTE_W-1:0] DEVICE_ADDR_RESET = 8'hBB;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ADDR = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_NONE     = 2'd0,
      STATUS_ACCEPTED = 2'd1,
      STATUS_BAD_SUM  = 2'd2,
      STATUS_BAD_ADDR = 2'd3
   } status_type;

   // one-hot position within a frame
   typedef enum logic [4:0] {
      POS_WAIT = 5'b00001,
      POS_ADDR = 5'b00010,
      POS_CMD  = 5'b00100,
      POS_DATA = 5'b01000,
      POS_SUM  = 5'b10000
   } pos_type;

   typedef struct packed {
      status_type         status;
      logic [VALVE_W-1:0] valves;
      logic               motor_run;
      logic               led;
   } result_type;

endpackage

// ----- sv/fvcr_parser.sv -----
// ---------------------------------------------------------------------------
// fvcr_parser: frame parser and output latches
// Tracks the frame position and checksum, and produces the status and held
// outputs for the byte presented on rx_byte.
// ---------------------------------------------------------------------------
module fvcr_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [fvcr_pkg::BYTE_W-1:0]  rx_byte,
   input  logic [fvcr_pkg::BYTE_W-1:0]  start_byte,
   input  logic [fvcr_pkg::BYTE_W-1:0]  device_address,
   output fvcr_pkg::result_type         result
);

   fvcr_pkg::pos_type               pos_ff, pos_in;
   logic [fvcr_pkg::BYTE_W-1:0]     xor_ff, xor_in;
   logic [fvcr_pkg::BYTE_W-1:0]     addr_ff, addr_in;
   logic [fvcr_pkg::BYTE_W-1:0]     cmd_ff, cmd_in;
   logic [fvcr_pkg::VALVE_W-1:0]    valve_ff, valve_in;
   logic                            run_ff, run_in;
   logic                            led_ff, led_in;
   fvcr_pkg::status_type            status;

   always_comb begin
      pos_in   = pos_ff;
      xor_in   = xor_ff;
      addr_in  = addr_ff;
      cmd_in   = cmd_ff;
      valve_in = valve_ff;
      run_in   = run_ff;
      led_in   = led_ff;
      status   = fvcr_pkg::STATUS_NONE;
      unique case (pos_ff)
         fvcr_pkg::POS_ADDR: begin
            addr_in = rx_byte;
            xor_in  = xor_ff ^ rx_byte;
            pos_in  = fvcr_pkg::POS_CMD;
         end
         fvcr_pkg::POS_CMD: begin
            cmd_in = rx_byte;
            xor_in = xor_ff ^ rx_byte;
            pos_in = fvcr_pkg::POS_DATA;
         end
         fvcr_pkg::POS_DATA: begin
            xor_in = xor_ff ^ rx_byte;
            pos_in = fvcr_pkg::POS_SUM;
         end
         fvcr_pkg::POS_SUM: begin
            pos_in = fvcr_pkg::POS_WAIT;
            if (addr_ff != device_address) begin
               status = fvcr_pkg::STATUS_BAD_ADDR;
            end else if (rx_byte != xor_ff) begin
               status = fvcr_pkg::STATUS_BAD_SUM;
            end else begin
               status   = fvcr_pkg::STATUS_ACCEPTED;
               valve_in = cmd_ff[fvcr_pkg::VALVE_W-1:0];
               run_in   = cmd_ff[fvcr_pkg::BYTE_W-1];
               led_in   = ~led_ff;
            end
         end
         default: begin
            // waiting, or an illegal code: hunt for the start byte
            if (rx_byte == start_byte) begin
               xor_in = start_byte;
               pos_in = fvcr_pkg::POS_ADDR;
            end else begin
               pos_in = fvcr_pkg::POS_WAIT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= fvcr_pkg::POS_WAIT;
         xor_ff   <= '0;
         addr_ff  <= '0;
         cmd_ff   <= '0;
         valve_ff <= '0;
         run_ff   <= 1'b0;
         led_ff   <= 1'b0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         xor_ff   <= xor_in;
         addr_ff  <= addr_in;
         cmd_ff   <= cmd_in;
         valve_ff <= valve_in;
         run_ff   <= run_in;
         led_ff   <= led_in;
      end
   end

   assign result.status    = status;
   assign result.valves    = valve_in;
   assign result.motor_run = run_in;
   assign result.led       = led_in;

endmodule

// ----- sv/framed_valve_command_receiver.sv -----
// ---------------------------------------------------------------------------
// framed_valve_command_receiver: serial valve command frame receiver
// Parses start/address/command/data/checksum frames byte by byte and drives
// the valve, motor-run and activity LED outputs.
// ---------------------------------------------------------------------------
//
//  channel  direction  payload                                 handshake
//  req_     in         rx_byte                                 tvalid/tready
//  rsp_     out        frame_status, valves, motor_run, led    tvalid/tready
//  csr_     in         start_byte (0), device_address (1)      we only
//
//  One byte per cycle while rsp_ does not stall: each transfer on req_ is
//  parsed in the cycle it is taken and its result lands in the rsp_ register
//  at the same edge. The single output register sets the throughput.
//  req_tready stays high while the output register is empty or being drained,
//  so a stall on rsp_ holds exactly one result and back-pressures req_.
//  Synchronous reset clears the parser to the waiting state, all valves off,
//  motor flag and LED low, and restores the register defaults.
//
module framed_valve_command_receiver (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [1:0] frame_status, [8:2] valve_outputs,
                                    // [9] motor_run, [10] activity_led, rest 0
   // configuration writes
   input  logic        csr_we,
   input  logic [fvcr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [fvcr_pkg::BYTE_W-1:0] start_byte_ff;
   logic [fvcr_pkg::BYTE_W-1:0] device_addr_ff;
   logic                        rsp_valid_ff;
   logic [15:0]                 rsp_data_ff, rsp_data_in;
   logic                        req_xfer;
   fvcr_pkg::result_type        result;

   // accept a byte whenever the output slot is free or drains this cycle
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_xfer   = req_tvalid & req_tready;

   // configuration registers: no read-back
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff  <= fvcr_pkg::START_BYTE_RESET;
         device_addr_ff <= fvcr_pkg::DEVICE_ADDR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            fvcr_pkg::CSR_START_BYTE:  start_byte_ff  <= csr_wdata;
            fvcr_pkg::CSR_DEVICE_ADDR: device_addr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   fvcr_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_xfer),
      .rx_byte        (req_tdata),
      .start_byte     (start_byte_ff),
      .device_address (device_addr_ff),
      .result         (result)
   );

   // pack the result, first field in the lowest bits
   assign rsp_data_in = {5'b0, result.led, result.motor_run, result.valves,
                         result.status};

   // output register: load on a request transfer, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
